[rtl/core/mmbd_pkg.sv]
// mmbd_pkg: shared types and constants for the min/max bucket decimator.
// Used by mmbd_front, mmbd_back, the top level and the bench; depends on nothing.
package mmbd_pkg;

  localparam int unsigned LIMIT_RESET = 512;
  localparam int unsigned LIMIT_FLOOR = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT   = 2'd0,
    CFG_POINT_LIMIT    = 2'd1,
    CFG_CHANNEL_SELECT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic two;
    logic eoc;
  } cmd_flags_t;

  localparam int unsigned FLAG_BITS = $bits(cmd_flags_t);

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

[rtl/core/mmbd_front.sv]
// mmbd_front: accepts samples, tracks curve position, bucket bounds and extremes,
// and issues one- or two-point commands. Depends on mmbd_pkg.
module mmbd_front #(
  parameter int COUNT_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int HEIGHT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [COUNT_BITS-1:0]         sample_count,
  input  logic [COUNT_BITS-1:0]         point_limit,
  input  logic                          channel_select,
  input  logic                          take,
  input  logic [HEIGHT_BITS-1:0]        height_um,
  input  logic signed [VALUE_BITS-1:0]  backscatter_value,
  input  logic signed [VALUE_BITS-1:0]  transmission_value,
  output logic                          push,
  output mmbd_pkg::cmd_flags_t          flags,
  output logic [HEIGHT_BITS-1:0]        h0,
  output logic [VALUE_BITS-1:0]         v0,
  output logic [HEIGHT_BITS-1:0]        h1,
  output logic [VALUE_BITS-1:0]         v1
);
  import mmbd_pkg::*;

  localparam int ACC_BITS = 2 * COUNT_BITS + 1;

  logic [COUNT_BITS-1:0]         position, position_next;
  logic [ACC_BITS-1:0]           acc, acc_next;
  logic signed [VALUE_BITS-1:0]  min_value, min_value_next, max_value, max_value_next;
  logic [HEIGHT_BITS-1:0]        min_height, min_height_next, max_height, max_height_next;
  logic [COUNT_BITS-1:0]         min_position, min_position_next;
  logic [COUNT_BITS-1:0]         max_position, max_position_next;

  logic signed [VALUE_BITS-1:0]  v;
  logic                          is_last, pass, close;
  logic [COUNT_BITS-1:0]         inner, buckets;
  logic [ACC_BITS-1:0]           inner_ext, buckets_ext;
  logic signed [VALUE_BITS-1:0]  mn_v, mx_v;
  logic [HEIGHT_BITS-1:0]        mn_h, mx_h;
  logic [COUNT_BITS-1:0]         mn_p, mx_p;

  always_comb begin
    v           = channel_select ? transmission_value : backscatter_value;
    is_last     = (sample_count != '0) && (position == sample_count - 1'b1);
    pass        = (sample_count <= point_limit) ||
                  (point_limit <= COUNT_BITS'(LIMIT_FLOOR)) ||
                  (position >= sample_count);
    inner       = sample_count - COUNT_BITS'(2);
    buckets     = point_limit >> 1;
    inner_ext   = ACC_BITS'(inner);
    buckets_ext = ACC_BITS'(buckets);
    close       = acc < buckets_ext;

    if (min_position == '0) begin
      mn_v = v; mn_h = height_um; mn_p = position;
      mx_v = v; mx_h = height_um; mx_p = position;
    end else begin
      mn_v = min_value; mn_h = min_height; mn_p = min_position;
      mx_v = max_value; mx_h = max_height; mx_p = max_position;
      if (v < min_value) begin
        mn_v = v; mn_h = height_um; mn_p = position;
      end
      if (v > max_value) begin
        mx_v = v; mx_h = height_um; mx_p = position;
      end
    end
  end

  always_comb begin
    push      = 1'b0;
    flags.two = 1'b0;
    flags.eoc = 1'b0;
    h0 = height_um;
    v0 = v;
    h1 = mx_h;
    v1 = mx_v;
    position_next     = is_last ? '0 : position + 1'b1;
    acc_next          = acc;
    min_value_next    = min_value;
    min_height_next   = min_height;
    min_position_next = min_position;
    max_value_next    = max_value;
    max_height_next   = max_height;
    max_position_next = max_position;

    priority if (pass || is_last) begin
      push      = 1'b1;
      flags.eoc = is_last;
    end else if (position == '0) begin
      push              = 1'b1;
      acc_next          = inner_ext - buckets_ext;
      min_position_next = '0;
    end else begin
      min_value_next    = mn_v;
      min_height_next   = mn_h;
      max_value_next    = mx_v;
      max_height_next   = mx_h;
      max_position_next = mx_p;
      if (close) begin
        push              = 1'b1;
        acc_next          = acc + inner_ext - buckets_ext;
        min_position_next = '0;
        if (mn_p == mx_p) begin
          h0 = mn_h; v0 = mn_v;
        end else if (mn_p < mx_p) begin
          flags.two = 1'b1;
          h0 = mn_h; v0 = mn_v;
          h1 = mx_h; v1 = mx_v;
        end else begin
          flags.two = 1'b1;
          h0 = mx_h; v0 = mx_v;
          h1 = mn_h; v1 = mn_v;
        end
      end else begin
        acc_next          = acc - buckets_ext;
        min_position_next = mn_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      acc          <= '0;
      min_value    <= '0;
      min_height   <= '0;
      min_position <= '0;
      max_value    <= '0;
      max_height   <= '0;
      max_position <= '0;
    end else if (take) begin
      position     <= position_next;
      acc          <= acc_next;
      min_value    <= min_value_next;
      min_height   <= min_height_next;
      min_position <= min_position_next;
      max_value    <= max_value_next;
      max_height   <= max_height_next;
      max_position <= max_position_next;
    end
  end

endmodule

[rtl/core/mmbd_queue.sv]
// mmbd_queue: small command FIFO between front and back.
// Does not depend on mmbd_pkg; width and depth are parameters.
module mmbd_queue #(
  parameter int WIDTH = 106,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign full    = count == CNT_BITS'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end
  end

endmodule

[rtl/core/mmbd_back.sv]
// mmbd_back: expands queued commands into single points and holds the output register.
// Depends on mmbd_pkg (cmd_flags_t, phase_t).
module mmbd_back #(
  parameter int VALUE_BITS  = 32,
  parameter int HEIGHT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  mmbd_pkg::cmd_flags_t          flags,
  input  logic [HEIGHT_BITS-1:0]        h0,
  input  logic [VALUE_BITS-1:0]         v0,
  input  logic [HEIGHT_BITS-1:0]        h1,
  input  logic [VALUE_BITS-1:0]         v1,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [HEIGHT_BITS-1:0]        point_height,
  output logic signed [VALUE_BITS-1:0]  point_value,
  output logic                          last_of_run,
  output logic                          end_of_curve
);
  import mmbd_pkg::*;

  phase_t phase, phase_next;
  logic   load, final_pt;

  assign load     = head_valid && (!out_valid || out_ready);
  assign final_pt = !flags.two || (phase == PH_SECOND);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_FIRST:  if (load && flags.two) phase_next = PH_SECOND;
      PH_SECOND: if (load) phase_next = PH_FIRST;
      default:   phase_next = PH_FIRST;
    endcase
  end

  always_comb begin
    pop = load && final_pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point_height <= (phase == PH_SECOND) ? h1 : h0;
      point_value  <= (phase == PH_SECOND) ? v1 : v0;
      last_of_run  <= final_pt;
      end_of_curve <= flags.eoc && !flags.two;
    end
  end

endmodule

[rtl/core/min_max_bucket_decimator.sv]
// min_max_bucket_decimator: top level; configuration registers, front, queue, back.
// Depends on mmbd_pkg, mmbd_front, mmbd_queue, mmbd_back.
//
// Usage: program sample_count, point_limit and channel_select through the cfg
// channel (cfg_index, cfg_data; cfg_ready is always high) while the block is idle,
// then stream one curve of samples on in_valid/in_ready. Each request yields zero,
// one or two points on out_valid/out_ready; last_of_run marks the final point of a
// request and end_of_curve the point for the curve's last sample.
// A sample's command enters the queue when the sample is accepted; its first point
// is then loaded from the queue head into the output register. The front stage
// takes one sample per cycle, and in_ready drops only when the queue is full; the
// output port moves one point per cycle while out_ready is high, so a two-point
// bucket close occupies it for both. The four-entry command queue absorbs that.
// When the receiver stalls, the output register holds its point and the queue
// fills, after which in_ready falls. Reset empties the queue and output register,
// returns the curve position, bucket accumulator and extremes to zero, and loads
// sample_count 0, point_limit 512, channel_select 0.
module min_max_bucket_decimator #(
  parameter int COUNT_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int HEIGHT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mmbd_pkg::cfg_index_t          cfg_index,
  input  logic [COUNT_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [HEIGHT_BITS-1:0]        height_um,
  input  logic signed [VALUE_BITS-1:0]  backscatter_value,
  input  logic signed [VALUE_BITS-1:0]  transmission_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [HEIGHT_BITS-1:0]        point_height,
  output logic signed [VALUE_BITS-1:0]  point_value,
  output logic                          last_of_run,
  output logic                          end_of_curve
);
  import mmbd_pkg::*;

  localparam int PT_BITS = HEIGHT_BITS + VALUE_BITS;
  localparam int Q_WIDTH = FLAG_BITS + 2 * PT_BITS;

  logic [COUNT_BITS-1:0] sample_count, point_limit;
  logic                  channel_select;

  logic                  take, q_push, q_pop, q_full, q_empty;
  cmd_flags_t            f_flags, b_flags;
  logic [HEIGHT_BITS-1:0] f_h0, f_h1, b_h0, b_h1;
  logic [VALUE_BITS-1:0]  f_v0, f_v1, b_v0, b_v1;
  logic [Q_WIDTH-1:0]     q_wr, q_rd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      point_limit    <= COUNT_BITS'(LIMIT_RESET);
      channel_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT:   sample_count   <= cfg_data;
        CFG_POINT_LIMIT:    point_limit    <= cfg_data;
        CFG_CHANNEL_SELECT: channel_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mmbd_front #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .sample_count      (sample_count),
    .point_limit       (point_limit),
    .channel_select    (channel_select),
    .take              (take),
    .height_um         (height_um),
    .backscatter_value (backscatter_value),
    .transmission_value(transmission_value),
    .push              (q_push),
    .flags             (f_flags),
    .h0                (f_h0),
    .v0                (f_v0),
    .h1                (f_h1),
    .v1                (f_v1)
  );

  assign q_wr = {f_flags, f_h0, f_v0, f_h1, f_v1};
  assign {b_flags, b_h0, b_v0, b_h1, b_v1} = q_rd;

  mmbd_queue #(
    .WIDTH(Q_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (take && q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  mmbd_back #(
    .VALUE_BITS (VALUE_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .flags       (b_flags),
    .h0          (b_h0),
    .v0          (b_v0),
    .h1          (b_h1),
    .v1          (b_v1),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_height(point_height),
    .point_value (point_value),
    .last_of_run (last_of_run),
    .end_of_curve(end_of_curve)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_eoc_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_curve) |-> last_of_run)
    else $error("end_of_curve on a point that is not last of its request");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_full && !q_pop) |=> q_full)
    else $error("queue drained without a pop");

endmodule

[bench/mmbd_checker.sv]
`timescale 1ns / 1ps
// mmbd_checker: watches the register, sample and point channels of the decimator,
// predicts the points each request yields and compares them in order. Uses mmbd_pkg.
module mmbd_checker #(
  parameter int COUNT_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int HEIGHT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  mmbd_pkg::cfg_index_t          cfg_index,
  input  logic [COUNT_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [HEIGHT_BITS-1:0]        height_um,
  input  logic signed [VALUE_BITS-1:0]  backscatter_value,
  input  logic signed [VALUE_BITS-1:0]  transmission_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [HEIGHT_BITS-1:0]        point_height,
  input  logic signed [VALUE_BITS-1:0]  point_value,
  input  logic                          last_of_run,
  input  logic                          end_of_curve,
  output int unsigned                   pending,
  output int unsigned                   fail_count,
  output int unsigned                   points_checked
);
  import mmbd_pkg::*;

  localparam int ACC_BITS = 2 * COUNT_BITS + 1;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic [VALUE_BITS-1:0]  value;
    logic                   last;
    logic                   eoc;
  } point_t;

  logic [COUNT_BITS-1:0]        cur_count;
  logic [COUNT_BITS-1:0]        cur_limit;
  logic                         cur_channel;
  logic [COUNT_BITS-1:0]        position;
  logic [ACC_BITS-1:0]          acc;
  logic signed [VALUE_BITS-1:0] lo_val;
  logic signed [VALUE_BITS-1:0] hi_val;
  logic [HEIGHT_BITS-1:0]       lo_h;
  logic [HEIGHT_BITS-1:0]       hi_h;
  logic [COUNT_BITS-1:0]        lo_pos;
  logic [COUNT_BITS-1:0]        hi_pos;
  point_t                       pending_points[$];
  point_t                       want;

  task automatic note_point(input logic [HEIGHT_BITS-1:0] h, input logic [VALUE_BITS-1:0] v,
                            input logic last, input logic eoc);
    point_t pt;
    pt.height = h;
    pt.value  = v;
    pt.last   = last;
    pt.eoc    = eoc;
    pending_points.push_back(pt);
  endtask

  task automatic decimate(input logic [HEIGHT_BITS-1:0] h, input logic signed [VALUE_BITS-1:0] v);
    logic [COUNT_BITS-1:0] p;
    logic [ACC_BITS-1:0]   inner;
    logic [ACC_BITS-1:0]   buckets;
    logic                  closing;
    logic                  passing;
    p = position;
    closing = (cur_count != '0) && (p == cur_count - 1'b1);
    passing = (cur_count <= cur_limit) || (cur_limit <= LIMIT_FLOOR) || (p >= cur_count);
    position = closing ? '0 : p + 1'b1;
    inner = {{(ACC_BITS-COUNT_BITS){1'b0}}, cur_count} - 2'd2;
    buckets = {{(ACC_BITS-COUNT_BITS){1'b0}}, cur_limit >> 1};
    if (passing || closing) begin
      note_point(h, v, 1'b1, closing);
    end else if (p == '0) begin
      acc = inner - buckets;
      lo_pos = '0;
      note_point(h, v, 1'b1, 1'b0);
    end else begin
      if (lo_pos == '0) begin
        lo_val = v;
        lo_h   = h;
        lo_pos = p;
        hi_val = v;
        hi_h   = h;
        hi_pos = p;
      end else begin
        if (v < lo_val) begin
          lo_val = v;
          lo_h   = h;
          lo_pos = p;
        end
        if (v > hi_val) begin
          hi_val = v;
          hi_h   = h;
          hi_pos = p;
        end
      end
      if (acc < buckets) begin
        acc = acc + inner - buckets;
        if (lo_pos == hi_pos) begin
          note_point(lo_h, lo_val, 1'b1, 1'b0);
        end else if (lo_pos < hi_pos) begin
          note_point(lo_h, lo_val, 1'b0, 1'b0);
          note_point(hi_h, hi_val, 1'b1, 1'b0);
        end else begin
          note_point(hi_h, hi_val, 1'b0, 1'b0);
          note_point(lo_h, lo_val, 1'b1, 1'b0);
        end
        lo_pos = '0;
      end else begin
        acc = acc - buckets;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_count      = '0;
      cur_limit      = COUNT_BITS'(LIMIT_RESET);
      cur_channel    = 1'b0;
      position       = '0;
      acc            = '0;
      lo_val         = '0;
      lo_h           = '0;
      lo_pos         = '0;
      hi_val         = '0;
      hi_h           = '0;
      hi_pos         = '0;
      fail_count     = 0;
      points_checked = 0;
      pending_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT:   cur_count = cfg_data;
          CFG_POINT_LIMIT:    cur_limit = cfg_data;
          CFG_CHANNEL_SELECT: cur_channel = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decimate(height_um, cur_channel ? transmission_value : backscatter_value);
      end
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          $error("point with no request outstanding: height %0h value %0d",
                 point_height, point_value);
          fail_count++;
        end else begin
          want = pending_points.pop_front();
          points_checked++;
          if (point_height !== want.height) begin
            $error("point_height: expected %0h, actual %0h", want.height, point_height);
            fail_count++;
          end
          if (point_value !== want.value) begin
            $error("point_value: expected %0d, actual %0d", $signed(want.value), point_value);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
            fail_count++;
          end
          if (end_of_curve !== want.eoc) begin
            $error("end_of_curve: expected %0b, actual %0b", want.eoc, end_of_curve);
            fail_count++;
          end
        end
      end
    end
    pending = pending_points.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: feeds curves of samples and register settings to min_max_bucket_decimator
// with bursty requests and a stalling receiver; mmbd_checker judges every point.
module tb_top;
  import mmbd_pkg::*;

  localparam int COUNT_BITS     = 16;
  localparam int VALUE_BITS     = 32;
  localparam int HEIGHT_BITS    = 20;
  localparam int LONG_HOLD      = 100;
  localparam int SETTLE         = 12;
  localparam int RANDOM_SAMPLES = 2000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  cfg_index_t                   cfg_index = CFG_SAMPLE_COUNT;
  logic [COUNT_BITS-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [HEIGHT_BITS-1:0]       height_um = '0;
  logic signed [VALUE_BITS-1:0] backscatter_value = '0;
  logic signed [VALUE_BITS-1:0] transmission_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [HEIGHT_BITS-1:0]       point_height;
  logic signed [VALUE_BITS-1:0] point_value;
  logic                         last_of_run;
  logic                         end_of_curve;
  int unsigned                  pending;
  int unsigned                  fail_count;
  int unsigned                  points_checked;

  int unsigned samples_sent = 0;
  int unsigned curves_started = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  min_max_bucket_decimator #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) uut (.*);

  mmbd_checker #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) point_check (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: stretches of differing stall density, plus long holds on demand
  initial begin : sink
    int unsigned style;
    int unsigned stretch;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      style = $urandom_range(0, 3);
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_requests != hold_served) begin
          out_ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          hold_served++;
        end
        case (style)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) == 1);
          2: out_ready = ($urandom_range(0, 7) != 0);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = COUNT_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int unsigned count, input int unsigned limit, input bit chan);
    write_reg(CFG_SAMPLE_COUNT, count);
    write_reg(CFG_POINT_LIMIT, limit);
    write_reg(CFG_CHANNEL_SELECT, {31'b0, chan});
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_sample(input logic [HEIGHT_BITS-1:0] h, input logic [VALUE_BITS-1:0] bs,
                             input logic [VALUE_BITS-1:0] tr);
    in_valid = 1'b1;
    height_um = h;
    backscatter_value = bs;
    transmission_value = tr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic pace(input bit gapless);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gapless) gap = 0;
      else if ($urandom_range(0, 5) == 0) gap = $urandom_range(5, 12);
      else gap = $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned vmode);
    logic [VALUE_BITS-1:0] v;
    case (vmode)
      0: v = VALUE_BITS'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = VALUE_BITS'(32'h0001_0000);
        endcase
      end
      2: v = VALUE_BITS'(int'($urandom_range(0, 16)) - 8);
      default: v = VALUE_BITS'($urandom_range(0, 3)) << 16;
    endcase
    return v;
  endfunction

  task automatic send_curve(input int unsigned count, input bit gapless);
    int unsigned vmode;
    int unsigned hmode;
    logic [HEIGHT_BITS-1:0] h;
    vmode = $urandom_range(0, 3);
    hmode = $urandom_range(0, 7);
    h = HEIGHT_BITS'($urandom_range(0, (1 << HEIGHT_BITS) - 1));
    curves_started++;
    for (int unsigned i = 0; i < count; i++) begin
      pace(gapless);
      if (!gapless && $urandom_range(0, 299) == 0) drain();
      send_sample(h, pick_value(vmode), pick_value(vmode));
      if (hmode == 0) h = HEIGHT_BITS'($urandom);
      else if (hmode == 1) h = h + HEIGHT_BITS'($urandom_range(0, 40000));
      else h = h + HEIGHT_BITS'($urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    logic [VALUE_BITS-1:0] v_min;
    logic [VALUE_BITS-1:0] v_max;
    logic [VALUE_BITS-1:0] desc_vals[10];
    logic [VALUE_BITS-1:0] asc_vals[8];
    int unsigned phase;
    int unsigned kind;
    int unsigned count;
    int unsigned limit;
    int unsigned len;
    int unsigned start_count;
    bit          chan;

    v_min = {1'b1, {(VALUE_BITS-1){1'b0}}};
    v_max = {1'b0, {(VALUE_BITS-1){1'b1}}};
    desc_vals = '{0, 5, 5, -3, 5, 7, 7, 7, 7, 9};
    asc_vals = '{1, -100, 200, 300, 300, v_min, v_max, 4};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset registers give pass-through; field extremes
    send_sample('0, v_min, v_max);
    send_sample('1, v_max, v_min);
    drain();

    // two buckets of four: max before min, then a flat bucket giving one point
    configure(10, 4, 1'b1);
    for (int i = 0; i < 10; i++) begin
      send_sample(HEIGHT_BITS'(100 + i / 2), VALUE_BITS'($urandom), desc_vals[i]);
    end
    drain();

    // buckets of two: min before max, equal values, value extremes
    configure(8, 6, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_sample(HEIGHT_BITS'(5000 + 7 * i), asc_vals[i], VALUE_BITS'($urandom));
    end
    drain();

    // zero limit passes everything; the curve is left unfinished on purpose
    configure(5, 0, 1'b0);
    for (int i = 0; i < 3; i++) begin
      send_sample(HEIGHT_BITS'($urandom), VALUE_BITS'($urandom), VALUE_BITS'($urandom));
    end
    drain();

    // long receiver hold while requests keep coming
    configure(0, LIMIT_RESET, 1'b1);
    hold_requests++;
    send_curve(40, 1'b1);
    drain();

    start_count = samples_sent;
    phase = 0;
    while (samples_sent < start_count + RANDOM_SAMPLES) begin
      kind = (phase < 10) ? phase : $urandom_range(0, 9);
      chan = ($urandom_range(0, 1) == 1);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          count = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(4, 60);
          limit = $urandom_range(3, count - 1);
        end
        6: begin
          count = $urandom_range(1, 40);
          limit = $urandom_range(0, 1) ? 65535 : $urandom_range(count, 200);
        end
        7: begin
          count = $urandom_range(3, 40);
          limit = $urandom_range(0, LIMIT_FLOOR);
        end
        8: begin
          count = 0;
          limit = $urandom_range(0, 1000);
        end
        default: begin
          count = 65535;
          limit = $urandom_range(0, 1) ? 65535 : $urandom_range(3, 600);
        end
      endcase
      configure(count, limit, chan);
      len = count;
      if (count == 0 || count == 65535) len = $urandom_range(10, 80);
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(1, count);
      else if ($urandom_range(0, 7) == 0) len = count + $urandom_range(1, 10);
      send_curve(len, $urandom_range(0, 4) == 0);
      drain();
      phase++;
    end

    $display("tb_top: %0d samples in %0d curves across %0d random settings, %0d points compared",
             samples_sent, curves_started, phase, points_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[min_max_bucket_decimator.f]
rtl/core/mmbd_pkg.sv
rtl/core/mmbd_front.sv
rtl/core/mmbd_queue.sv
rtl/core/mmbd_back.sv
rtl/core/min_max_bucket_decimator.sv
bench/mmbd_checker.sv
bench/tb_top.sv
